>>> hw/rtl/mcst_pkg.sv
package mcst_pkg;

    localparam int unsigned SECTOR_BYTES_DEF = 128;

    localparam logic [7:0] SEL_BYTE  = 8'h81;
    localparam logic [7:0] READ_CMD  = 8'h52;
    localparam logic [7:0] WRITE_CMD = 8'h57;

    typedef enum logic [1:0] {
        OP_START_READ  = 2'd0,
        OP_START_WRITE = 2'd1,
        OP_RX_BYTE     = 2'd2,
        OP_TIMEOUT     = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_CMD  = 5'd1,
        PH_LET  = 5'd2,
        PH_Z0   = 5'd3,
        PH_Z1   = 5'd4,
        PH_HI   = 5'd5,
        PH_LO   = 5'd6,
        PH_ACK0 = 5'd7,
        PH_ACK1 = 5'd8,
        PH_CF0  = 5'd9,
        PH_CF1  = 5'd10,
        PH_DATA = 5'd11,
        PH_SUM  = 5'd12,
        PH_TA0  = 5'd13,
        PH_TA1  = 5'd14,
        PH_END  = 5'd15
    } phase_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       keep_selected;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [6:0] data_index;
        logic       done_res;
        logic       status;
    } result_t;

endpackage

>>> hw/rtl/mcst_if.sv
interface mcst_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [9:0] sector;
    logic [7:0] rx_byte;
    logic [7:0] wr_byte;

    modport source (output valid, output opcode, output sector, output rx_byte,
                    output wr_byte, input ready);
    modport sink (input valid, input opcode, input sector, input rx_byte,
                  input wr_byte, output ready);
endinterface

interface mcst_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       keep_selected;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic       done_res;
    logic       status;

    modport source (output valid, output tx_valid, output tx_byte, output keep_selected,
                    output data_valid, output data_byte, output data_index,
                    output done_res, output status, input ready);
    modport sink (input valid, input tx_valid, input tx_byte, input keep_selected,
                  input data_valid, input data_byte, input data_index,
                  input done_res, input status, output ready);
endinterface

>>> hw/rtl/memory_card_sector_transfer.sv
// Host-side sequencer for memory card sector reads and writes. A start beat
// opens a read or write and answers with the select byte; each later response
// beat answers with the next byte to exchange, or the done result at the end,
// read data being passed out with its index and write data folded into an XOR
// checksum. A timeout right after the select byte aborts with a no-card status.
// Each beat is handled by the phase logic feeding a single result register,
// so one beat can be taken every cycle; the input stalls only while that result
// register is full and not being taken. Beats with no result leave it untouched.
module memory_card_sector_transfer #(
    parameter int unsigned SECTOR_BYTES = mcst_pkg::SECTOR_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    mcst_in_if.sink          req,
    mcst_out_if.source       rsp
);
    import mcst_pkg::*;

    localparam logic [7:0] LastCount = 8'(SECTOR_BYTES);

    phase_t     phase_reg, phase_next;
    logic [6:0] byte_count_reg, byte_count_next;
    logic       is_write_reg, is_write_next;
    logic [9:0] sector_reg, sector_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic       out_valid_reg;
    result_t    res_reg, res_next;
    logic       emit;
    logic       accept;
    opcode_t    op;
    logic [7:0] count_inc;

    assign op        = opcode_t'(req.opcode);
    assign accept    = req.valid && req.ready;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign count_inc = {1'b0, byte_count_reg} + 8'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        is_write_next    = is_write_reg;
        sector_next      = sector_reg;
        running_xor_next = running_xor_reg;
        res_next         = '0;
        emit             = 1'b1;
        unique case (op)
            OP_START_READ, OP_START_WRITE:
            begin
                is_write_next    = (op == OP_START_WRITE);
                sector_next      = req.sector;
                running_xor_next = {6'd0, req.sector[9:8]} ^ req.sector[7:0];
                byte_count_next  = '0;
                phase_next       = PH_CMD;
                res_next.tx_valid      = 1'b1;
                res_next.tx_byte       = SEL_BYTE;
                res_next.keep_selected = 1'b1;
            end
            OP_TIMEOUT:
            begin
                if (phase_reg == PH_CMD)
                begin
                    phase_next        = PH_IDLE;
                    res_next.done_res = 1'b1;
                    res_next.status   = 1'b1;
                end
                else
                begin
                    emit = 1'b0;
                end
            end
            OP_RX_BYTE:
            begin
                res_next.tx_valid      = 1'b1;
                res_next.keep_selected = 1'b1;
                unique case (phase_reg)
                    PH_CMD:
                    begin
                        res_next.tx_byte = is_write_reg ? WRITE_CMD : READ_CMD;
                        phase_next       = PH_LET;
                    end
                    PH_LET:  phase_next = PH_Z0;
                    PH_Z0:   phase_next = PH_Z1;
                    PH_Z1:
                    begin
                        res_next.tx_byte = {6'd0, sector_reg[9:8]};
                        phase_next       = PH_HI;
                    end
                    PH_HI:
                    begin
                        res_next.tx_byte = sector_reg[7:0];
                        phase_next       = PH_LO;
                    end
                    PH_LO, PH_CF1:
                    begin
                        if (is_write_reg || phase_reg == PH_CF1)
                        begin
                            byte_count_next = '0;
                            phase_next      = PH_DATA;
                            if (is_write_reg)
                            begin
                                running_xor_next = running_xor_reg ^ req.wr_byte;
                                res_next.tx_byte = req.wr_byte;
                            end
                        end
                        else
                        begin
                            phase_next = PH_ACK0;
                        end
                    end
                    PH_ACK0: phase_next = PH_ACK1;
                    PH_ACK1: phase_next = PH_CF0;
                    PH_CF0:  phase_next = PH_CF1;
                    PH_DATA:
                    begin
                        if (!is_write_reg)
                        begin
                            res_next.data_valid = 1'b1;
                            res_next.data_byte  = req.rx_byte;
                            res_next.data_index = byte_count_reg;
                        end
                        if (count_inc < LastCount)
                        begin
                            byte_count_next = count_inc[6:0];
                            if (is_write_reg)
                            begin
                                running_xor_next = running_xor_reg ^ req.wr_byte;
                                res_next.tx_byte = req.wr_byte;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SUM;
                            if (is_write_reg)
                            begin
                                res_next.tx_byte = running_xor_reg;
                            end
                        end
                    end
                    PH_SUM:
                    begin
                        if (is_write_reg)
                        begin
                            phase_next = PH_TA0;
                        end
                        else
                        begin
                            res_next.keep_selected = 1'b0;
                            phase_next             = PH_END;
                        end
                    end
                    PH_TA0:  phase_next = PH_TA1;
                    PH_TA1:
                    begin
                        res_next.keep_selected = 1'b0;
                        phase_next             = PH_END;
                    end
                    PH_END:
                    begin
                        res_next          = '0;
                        res_next.done_res = 1'b1;
                        phase_next        = PH_IDLE;
                    end
                    default:
                    begin
                        res_next   = '0;
                        emit       = 1'b0;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            byte_count_reg  <= '0;
            is_write_reg    <= 1'b0;
            sector_reg      <= '0;
            running_xor_reg <= '0;
            out_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                byte_count_reg  <= byte_count_next;
                is_write_reg    <= is_write_next;
                sector_reg      <= sector_next;
                running_xor_reg <= running_xor_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.tx_valid      = res_reg.tx_valid;
    assign rsp.tx_byte       = res_reg.tx_byte;
    assign rsp.keep_selected = res_reg.keep_selected;
    assign rsp.data_valid    = res_reg.data_valid;
    assign rsp.data_byte     = res_reg.data_byte;
    assign rsp.data_index    = res_reg.data_index;
    assign rsp.done_res      = res_reg.done_res;
    assign rsp.status        = res_reg.status;

endmodule

>>> tb/memory_card_sector_transfer_tb.sv
`timescale 1ns / 100ps

import mcst_pkg::*;

class sector_xfer_scoreboard;
    phase_t      phase;
    int unsigned byte_count;
    bit          is_write;
    logic [9:0]  sector_reg;
    logic [7:0]  running_xor;
    result_t     pending_results[$];
    int          errors;
    int          compared;
    int          reads_done;
    int          writes_done;
    int          aborts;
    int          data_bytes;

    function new();
        phase       = PH_IDLE;
        byte_count  = 0;
        is_write    = 0;
        sector_reg  = '0;
        running_xor = '0;
    endfunction

    function result_t tx_beat(logic [7:0] b, logic keep);
        result_t r;
        r = '0;
        r.tx_valid      = 1'b1;
        r.tx_byte       = b;
        r.keep_selected = keep;
        return r;
    endfunction

    // write data goes into the checksum, a read clocks out zeros
    function logic [7:0] data_out(logic [7:0] wr);
        if (is_write)
        begin
            running_xor = running_xor ^ wr;
            return wr;
        end
        return 8'h00;
    endfunction

    // returns 1 when the beat produces a result
    function bit note_request(opcode_t op, logic [9:0] sec, logic [7:0] rx, logic [7:0] wr);
        result_t     r;
        int unsigned idx;
        r = '0;
        if (op == OP_START_READ || op == OP_START_WRITE)
        begin
            is_write    = (op == OP_START_WRITE);
            sector_reg  = sec;
            running_xor = {6'b0, sec[9:8]} ^ sec[7:0];
            byte_count  = 0;
            phase       = PH_CMD;
            r = tx_beat(SEL_BYTE, 1'b1);
        end
        else if (op == OP_TIMEOUT)
        begin
            if (phase != PH_CMD)
                return 0;
            phase      = PH_IDLE;
            r.done_res = 1'b1;
            r.status   = 1'b1;
            aborts++;
        end
        else
        begin
            case (phase)
                PH_CMD:
                begin
                    r = tx_beat(is_write ? WRITE_CMD : READ_CMD, 1'b1);
                    phase = PH_LET;
                end
                PH_LET:
                begin
                    r = tx_beat(8'h00, 1'b1);
                    phase = PH_Z0;
                end
                PH_Z0:
                begin
                    r = tx_beat(8'h00, 1'b1);
                    phase = PH_Z1;
                end
                PH_Z1:
                begin
                    r = tx_beat({6'b0, sector_reg[9:8]}, 1'b1);
                    phase = PH_HI;
                end
                PH_HI:
                begin
                    r = tx_beat(sector_reg[7:0], 1'b1);
                    phase = PH_LO;
                end
                PH_LO:
                begin
                    if (is_write)
                    begin
                        byte_count = 0;
                        r = tx_beat(data_out(wr), 1'b1);
                        phase = PH_DATA;
                    end
                    else
                    begin
                        r = tx_beat(8'h00, 1'b1);
                        phase = PH_ACK0;
                    end
                end
                PH_ACK0:
                begin
                    r = tx_beat(8'h00, 1'b1);
                    phase = PH_ACK1;
                end
                PH_ACK1:
                begin
                    r = tx_beat(8'h00, 1'b1);
                    phase = PH_CF0;
                end
                PH_CF0:
                begin
                    r = tx_beat(8'h00, 1'b1);
                    phase = PH_CF1;
                end
                PH_CF1:
                begin
                    byte_count = 0;
                    r = tx_beat(data_out(wr), 1'b1);
                    phase = PH_DATA;
                end
                PH_DATA:
                begin
                    idx = byte_count;
                    if (byte_count + 1 < SECTOR_BYTES_DEF)
                    begin
                        byte_count++;
                        r = tx_beat(data_out(wr), 1'b1);
                    end
                    else
                    begin
                        r = tx_beat(is_write ? running_xor : 8'h00, 1'b1);
                        phase = PH_SUM;
                    end
                    if (!is_write)
                    begin
                        r.data_valid = 1'b1;
                        r.data_byte  = rx;
                        r.data_index = idx[6:0];
                        data_bytes++;
                    end
                end
                PH_SUM:
                begin
                    if (is_write)
                    begin
                        r = tx_beat(8'h00, 1'b1);
                        phase = PH_TA0;
                    end
                    else
                    begin
                        r = tx_beat(8'h00, 1'b0);
                        phase = PH_END;
                    end
                end
                PH_TA0:
                begin
                    r = tx_beat(8'h00, 1'b1);
                    phase = PH_TA1;
                end
                PH_TA1:
                begin
                    r = tx_beat(8'h00, 1'b0);
                    phase = PH_END;
                end
                PH_END:
                begin
                    r.done_res = 1'b1;
                    phase = PH_IDLE;
                    if (is_write)
                        writes_done++;
                    else
                        reads_done++;
                end
                default:
                begin
                    phase = PH_IDLE;
                    return 0;
                end
            endcase
        end
        pending_results.push_back(r);
        return 1;
    endfunction

    function int field_diff(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    function void check_response(result_t got);
        result_t want;
        int      bad;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        compared++;
        bad = field_diff("tx_valid", want.tx_valid, got.tx_valid)
            + field_diff("tx_byte", want.tx_byte, got.tx_byte)
            + field_diff("keep_selected", want.keep_selected, got.keep_selected)
            + field_diff("data_valid", want.data_valid, got.data_valid)
            + field_diff("data_byte", want.data_byte, got.data_byte)
            + field_diff("data_index", want.data_index, got.data_index)
            + field_diff("done_res", want.done_res, got.done_res)
            + field_diff("status", want.status, got.status);
        if (bad != 0)
            errors++;
    endfunction
endclass

module memory_card_sector_transfer_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_GOAL   = 1550;
    localparam int QUIET_FROM  = 1300;

    logic clk;
    logic rst_n;

    mcst_in_if  req_if ();
    mcst_out_if rsp_if ();

    memory_card_sector_transfer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    sector_xfer_scoreboard sb;

    bit      idle_on;
    bit      quiet;
    int      items;
    int      stall_left;
    int      dead_cycles;
    result_t got;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_beat(opcode_t op, logic [9:0] sec, logic [7:0] rx, logic [7:0] wr);
        int gap;
        if (idle_on && !quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid   = 1'b1;
        req_if.opcode  = op;
        req_if.sector  = sec;
        req_if.rx_byte = rx;
        req_if.wr_byte = wr;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        if (sb.note_request(op, sec, rx, wr))
            items++;
        if (items >= QUIET_FROM)
            quiet = 1'b1;
    endtask

    task automatic send_response();
        send_beat(OP_RX_BYTE, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_start(opcode_t op);
        send_beat(op, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_timeout();
        send_beat(OP_TIMEOUT, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver stalls
    initial
    begin
        rsp_if.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0 && !quiet)
            begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready = 1'b1;
                stall_left   = 0;
                if (idle_on && !quiet && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 17);
            end
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            begin
                got.tx_valid      = rsp_if.tx_valid;
                got.tx_byte       = rsp_if.tx_byte;
                got.keep_selected = rsp_if.keep_selected;
                got.data_valid    = rsp_if.data_valid;
                got.data_byte     = rsp_if.data_byte;
                got.data_index    = rsp_if.data_index;
                got.done_res      = rsp_if.done_res;
                got.status        = rsp_if.status;
                sb.check_response(got);
            end
            if ((rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                || (req_if.valid === 1'b1 && req_if.ready === 1'b1))
                dead_cycles = 0;
            else
                dead_cycles++;
            if (dead_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, sb.pending_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int kind;
        int n;
        sb             = new();
        idle_on        = 1'b1;
        quiet          = 1'b0;
        items          = 0;
        dead_cycles    = 0;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.opcode  = OP_RX_BYTE;
        req_if.sector  = '0;
        req_if.rx_byte = '0;
        req_if.wr_byte = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle beats, select abort, late timeout, restart while busy
        send_response();
        send_timeout();
        send_beat(OP_START_READ, 10'h3FF, 8'hFF, 8'hFF);
        send_beat(OP_TIMEOUT, 10'h000, 8'h00, 8'h00);
        send_beat(OP_START_WRITE, 10'h000, 8'h00, 8'h00);
        repeat (3) send_response();
        send_timeout();
        send_response();
        send_response();
        send_beat(OP_RX_BYTE, 10'h000, 8'h00, 8'hFF);
        send_beat(OP_RX_BYTE, 10'h3FF, 8'hFF, 8'h00);
        send_beat(OP_START_READ, 10'h2AA, 8'h55, 8'hAA);
        repeat (5) send_response();
        send_beat(OP_START_WRITE, 10'h155, 8'hAA, 8'h55);
        send_timeout();
        send_timeout();
        drain_results();

        while (items < ITEM_GOAL)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                send_start($urandom_range(0, 1) ? OP_START_WRITE : OP_START_READ);
                while (sb.phase != PH_IDLE)
                begin
                    if ($urandom_range(0, 49) == 0)
                        send_timeout();
                    else
                        send_response();
                end
            end
            else if (kind < 80)
            begin
                send_start($urandom_range(0, 1) ? OP_START_WRITE : OP_START_READ);
                send_timeout();
            end
            else if (kind < 90)
            begin
                send_start($urandom_range(0, 1) ? OP_START_WRITE : OP_START_READ);
                n = $urandom_range(0, 40);
                repeat (n) send_response();
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_beat(opcode_t'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 19) == 0)
                drain_results();
        end

        @(negedge clk);
        req_if.valid = 1'b0;
        drain_results();
        repeat (10) @(posedge clk);

        $display("%0d beats with results: %0d reads and %0d writes completed, %0d select aborts",
                 items, sb.reads_done, sb.writes_done, sb.aborts);
        $display("%0d results compared, %0d read data bytes passed through",
                 sb.compared, sb.data_bytes);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d errors, %0d results never seen", sb.errors,
                     sb.pending_results.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
